// ===== rtl/core/huffman_code_bit_packer_macros.svh =====
// assertion macros shared by the bit packer rtl
// expects i_clk and i_rst_n in the scope of use
`ifndef HUFFMAN_CODE_BIT_PACKER_MACROS_SVH
`define HUFFMAN_CODE_BIT_PACKER_MACROS_SVH

// same-cycle implication
`define HCBP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define HCBP_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/hcbp_pkg.sv =====
// types and constants for the huffman code bit packer
// no dependencies
`default_nettype none

package hcbp_pkg;

    localparam int MAX_CODE_LEN = 32;
    localparam int SYMBOL_COUNT = 256;
    localparam int WORD_BITS    = 32;
    localparam int LEN_LIMIT    = (MAX_CODE_LEN < WORD_BITS) ? MAX_CODE_LEN : WORD_BITS;
    localparam int ADDR_W       = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
    localparam int BYTE_TOP_BIT = 7;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_ENCODE = 2'd1;
    localparam logic [1:0] CMD_FLUSH  = 2'd2;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  symbol;
        logic [31:0] code_word;
        logic [5:0]  code_length;
    } t_in_item;

    typedef struct packed {
        logic [7:0] packed_byte;
        logic       last_of_run;
        logic       is_tail;
    } t_out_item;

    typedef struct packed {
        logic [5:0]  len;
        logic [31:0] word;
    } t_entry;

    typedef struct packed {
        logic        is_flush;
        logic [31:0] word;
        logic [5:0]  len;
    } t_job;

    typedef struct packed {
        logic valid;
        t_job job;
    } t_push;

endpackage

`default_nettype wire

// ===== rtl/core/huffman_code_bit_packer.sv =====
// top level of the huffman code bit packer
// depends on hcbp_pkg, hcbp_front, hcbp_queue, hcbp_back
`default_nettype none

// Load items write a 256-entry code table. Encode and flush items pass through a
// registered table-read stage into a four-deep job queue, so the front end keeps
// accepting items while the packer is busy until the queue fills. The packer picks
// up a job, then shifts its bits into bytes one byte step at a time; a flush emits
// any partial byte. It moves one byte per cycle into the output register unless a
// stalled output holds it back.
// Every output byte is held in a register until its transfer completes.
module huffman_code_bit_packer (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_stall,
    input  hcbp_pkg::t_in_item   i_item,
    output logic                 o_valid,
    input  wire                  i_stall,
    output hcbp_pkg::t_out_item  o_item
);

    hcbp_pkg::t_push push;
    hcbp_pkg::t_job  head;
    logic            full;
    logic            empty;
    logic            pop;

    hcbp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (i_item),
        .o_push  (push),
        .i_full  (full)
    );

    hcbp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .o_head  (head),
        .o_empty (empty),
        .i_pop   (pop)
    );

    hcbp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .i_empty (empty),
        .o_pop   (pop),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (o_item)
    );

endmodule

`default_nettype wire

// ===== rtl/core/hcbp_front.sv =====
// front end: accepts items, owns the code table, issues encode and flush jobs
// depends on hcbp_pkg
`default_nettype none

module hcbp_front (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_stall,
    input  hcbp_pkg::t_in_item  i_item,
    output hcbp_pkg::t_push     o_push,
    input  wire                 i_full
);

    hcbp_pkg::t_entry r_mem [hcbp_pkg::SYMBOL_COUNT];
    hcbp_pkg::t_entry r_rd;
    logic             r_s1_valid;
    logic             n_s1_valid;
    logic             r_s1_flush;

    logic                       accept;
    logic                       in_range;
    logic                       wr_en;
    logic                       rd_en;
    logic                       pushed;
    logic [hcbp_pkg::ADDR_W-1:0] addr;
    logic [5:0]                 sat_len;

    assign o_stall  = r_s1_valid && i_full;
    assign accept   = i_valid && !o_stall;
    assign in_range = {1'b0, i_item.symbol} < 9'(hcbp_pkg::SYMBOL_COUNT);
    assign addr     = i_item.symbol[hcbp_pkg::ADDR_W-1:0];
    assign wr_en    = accept && (i_item.cmd == hcbp_pkg::CMD_LOAD) && in_range;
    assign rd_en    = accept && (i_item.cmd == hcbp_pkg::CMD_ENCODE) && in_range;
    assign sat_len  = (i_item.code_length > 6'(hcbp_pkg::LEN_LIMIT)) ?
                      6'(hcbp_pkg::LEN_LIMIT) : i_item.code_length;
    assign pushed   = r_s1_valid && !i_full;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[addr] <= '{len: sat_len, word: i_item.code_word};
        end
        if (rd_en) begin
            r_rd <= r_mem[addr];
        end
    end

    always_comb begin
        n_s1_valid = r_s1_valid;
        if (pushed) begin
            n_s1_valid = 1'b0;
        end
        if (rd_en || (accept && (i_item.cmd == hcbp_pkg::CMD_FLUSH))) begin
            n_s1_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_flush <= (i_item.cmd == hcbp_pkg::CMD_FLUSH);
        end
    end

    always_comb begin
        o_push.valid        = r_s1_valid;
        o_push.job.is_flush = r_s1_flush;
        o_push.job.word     = r_s1_flush ? '0 : r_rd.word;
        o_push.job.len      = r_s1_flush ? '0 : r_rd.len;
    end

endmodule

`default_nettype wire

// ===== rtl/core/hcbp_queue.sv =====
// short job queue between front end and packer
// depends on hcbp_pkg
`default_nettype none

module hcbp_queue (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  hcbp_pkg::t_push  i_push,
    output logic             o_full,
    output hcbp_pkg::t_job   o_head,
    output logic             o_empty,
    input  wire              i_pop
);

    hcbp_pkg::t_job           r_slots [hcbp_pkg::QDEPTH];
    logic [hcbp_pkg::QAW-1:0] r_wp;
    logic [hcbp_pkg::QAW-1:0] r_rp;
    logic [hcbp_pkg::QAW:0]   r_count;
    logic [hcbp_pkg::QAW:0]   n_count;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_count == (hcbp_pkg::QAW+1)'(hcbp_pkg::QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_slots[r_rp];
    assign do_push = i_push.valid && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slots[r_wp] <= i_push.job;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/hcbp_back.sv =====
// packer: shifts code bits into bytes, one byte step per cycle unless stalled by the output, owns the output register
// depends on hcbp_pkg and the assertion macro header
`default_nettype none
`include "huffman_code_bit_packer_macros.svh"

module hcbp_back (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  hcbp_pkg::t_job      i_head,
    input  wire                 i_empty,
    output logic                o_pop,
    output logic                o_valid,
    input  wire                 i_stall,
    output hcbp_pkg::t_out_item o_item
);

    logic        r_busy;
    logic        n_busy;
    logic        r_flush;
    logic [31:0] r_word;
    logic [5:0]  r_len;
    logic [7:0]  r_partial;
    logic [7:0]  n_partial;
    logic [2:0]  r_bp;
    logic [2:0]  n_bp;
    logic        r_out_valid;
    logic        n_out_valid;
    hcbp_pkg::t_out_item r_out;
    hcbp_pkg::t_out_item n_out;

    logic       out_free;
    logic [3:0] space;
    logic [3:0] k;
    logic [3:0] fill;
    logic       emit;
    logic [7:0] mask;
    logic [7:0] merged;
    logic [5:0] len_next;
    logic       can_step;
    logic       load_out;

    assign out_free = !r_out_valid || !i_stall;
    assign space    = 4'd8 - {1'b0, r_bp};
    assign k        = (r_len < {2'b00, space}) ? r_len[3:0] : space;
    assign fill     = {1'b0, r_bp} + k;
    assign emit     = fill[3];
    assign mask     = 8'((9'd1 << k) - 9'd1);
    assign merged   = r_partial | 8'((r_word[7:0] & mask) << r_bp);
    assign len_next = r_len - {2'b00, k};
    assign can_step = r_busy && (r_flush ? ((r_bp == 3'd0) || out_free) : (!emit || out_free));
    assign o_pop    = !r_busy;

    always_comb begin
        n_busy    = r_busy;
        n_partial = r_partial;
        n_bp      = r_bp;
        load_out  = 1'b0;
        n_out     = r_out;
        if (!r_busy) begin
            n_busy = !i_empty && (i_head.is_flush || (i_head.len != 6'd0));
        end else if (can_step) begin
            if (r_flush) begin
                load_out  = (r_bp != 3'd0);
                n_out     = '{packed_byte: r_partial, last_of_run: 1'b1, is_tail: 1'b1};
                n_partial = '0;
                n_bp      = '0;
                n_busy    = 1'b0;
            end else begin
                // fewer than eight bits left after a full byte: no further byte follows
                load_out  = emit;
                n_out     = '{packed_byte: merged, last_of_run: (len_next < 6'd8),
                              is_tail: 1'b0};
                n_partial = emit ? 8'd0 : merged;
                n_bp      = fill[2:0];
                n_busy    = (len_next != 6'd0);
            end
        end
    end

    always_comb begin
        n_out_valid = r_out_valid && i_stall;
        if (load_out) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_partial   <= '0;
            r_bp        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_partial   <= n_partial;
            r_bp        <= n_bp;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_busy) begin
            r_flush <= i_head.is_flush;
            r_word  <= i_head.word;
            r_len   <= i_head.len;
        end else if (can_step && !r_flush) begin
            r_word  <= r_word >> k;
            r_len   <= len_next;
        end
        if (load_out) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

    `HCBP_ASSERT_IMP(a_busy_encode_has_bits,
        r_busy && !r_flush, r_len != 6'd0, "encode job active with no bits left")
    `HCBP_ASSERT_NXT(a_flush_clears,
        r_busy && r_flush && can_step, (r_bp == 3'd0) && (r_partial == 8'd0),
        "flush left packer state")
    `HCBP_ASSERT_NXT(a_emit_clears,
        r_busy && !r_flush && can_step && emit, (r_partial == 8'd0) && (r_bp == 3'd0),
        "full byte not cleared")
    `HCBP_ASSERT_IMP(a_no_overwrite,
        load_out, out_free, "output register overwritten while stalled")

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
// self-checking testbench for huffman_code_bit_packer: directed table then random traffic
// byte predictor with its own code table, random idle and stall bursts on both channels
// depends on hcbp_pkg and the huffman_code_bit_packer rtl
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CMD_NONE = 2'd3;
    localparam int RAND_ITEMS   = 235;
    localparam int QUIET_ITEMS  = 40;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 40;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        hcbp_pkg::t_in_item        item;
        logic                      typed;
        logic [2:0]                n_typed;
        hcbp_pkg::t_out_item [0:3] exp;
    } t_row;

    logic                i_clk   = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    logic                i_stall = 1'b0;
    hcbp_pkg::t_in_item  i_item  = '0;
    logic                o_stall;
    logic                o_valid;
    hcbp_pkg::t_out_item o_item;

    logic [31:0] code_tab_word [hcbp_pkg::SYMBOL_COUNT];
    int          code_tab_len  [hcbp_pkg::SYMBOL_COUNT];
    bit          tab_loaded    [hcbp_pkg::SYMBOL_COUNT];
    logic [7:0]  pend_byte = '0;
    logic [2:0]  pend_pos  = '0;
    logic [7:0]  loaded_syms [$];

    hcbp_pkg::t_out_item expected_bytes [$];
    t_row                dir_rows [$];

    int errors      = 0;
    int idle_cycles = 0;
    int stall_left  = 0;
    bit stalling    = 1'b0;
    bit quiet_phase = 1'b0;

    huffman_code_bit_packer uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (o_item)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic hcbp_pkg::t_out_item ob(logic [7:0] b, logic last, logic tail);
        hcbp_pkg::t_out_item o;
        o.packed_byte = b;
        o.last_of_run = last;
        o.is_tail     = tail;
        return o;
    endfunction

    // predicted bytes for one accepted item, updates the packer state
    function automatic void pack_step(input hcbp_pkg::t_in_item it,
                                      output hcbp_pkg::t_out_item [0:4] res,
                                      output int n);
        logic [31:0] code;
        int clen;
        n   = 0;
        res = '0;
        case (it.cmd)
            hcbp_pkg::CMD_LOAD: begin
                if (int'(it.symbol) < hcbp_pkg::SYMBOL_COUNT) begin
                    clen = (int'(it.code_length) > hcbp_pkg::LEN_LIMIT) ? hcbp_pkg::LEN_LIMIT
                                                                       : int'(it.code_length);
                    code_tab_word[it.symbol] = it.code_word;
                    code_tab_len[it.symbol]  = clen;
                    if (!tab_loaded[it.symbol]) begin
                        loaded_syms.push_back(it.symbol);
                    end
                    tab_loaded[it.symbol] = 1'b1;
                end
            end
            hcbp_pkg::CMD_ENCODE: begin
                if (int'(it.symbol) < hcbp_pkg::SYMBOL_COUNT) begin
                    code = code_tab_word[it.symbol];
                    clen = code_tab_len[it.symbol];
                    for (int k = 0; k < clen; k++) begin
                        if (code[k]) begin
                            pend_byte[pend_pos] = 1'b1;
                        end
                        if (pend_pos == 3'(hcbp_pkg::BYTE_TOP_BIT)) begin
                            if (n < 5) begin
                                res[n] = ob(pend_byte, 1'b0, 1'b0);
                                n++;
                            end
                            pend_byte = '0;
                        end
                        pend_pos = pend_pos + 3'd1;
                    end
                    if (n > 0) begin
                        res[n - 1].last_of_run = 1'b1;
                    end
                end
            end
            hcbp_pkg::CMD_FLUSH: begin
                if (pend_pos != 3'd0) begin
                    res[0] = ob(pend_byte, 1'b1, 1'b1);
                    n = 1;
                end
                pend_byte = '0;
                pend_pos  = '0;
            end
            default: begin
            end
        endcase
    endfunction

    function automatic void add_row(logic [1:0] cmd, logic [7:0] sym, logic [31:0] word,
                                    logic [5:0] len, int n_typed,
                                    hcbp_pkg::t_out_item [0:3] exp);
        t_row r;
        r.item.cmd         = cmd;
        r.item.symbol      = sym;
        r.item.code_word   = word;
        r.item.code_length = len;
        r.typed            = (n_typed >= 0);
        r.n_typed          = (n_typed >= 0) ? 3'(n_typed) : 3'd0;
        r.exp              = exp;
        dir_rows.push_back(r);
    endfunction

    task automatic report_error(string what, hcbp_pkg::t_out_item want,
                                hcbp_pkg::t_out_item got);
        errors++;
        if (errors <= MAX_REPORTS) begin
            $display("%0t %s: exp byte %02h last %0b tail %0b, got byte %02h last %0b tail %0b",
                     $realtime, what, want.packed_byte, want.last_of_run, want.is_tail,
                     got.packed_byte, got.last_of_run, got.is_tail);
        end
    endtask

    // one transfer on the input channel, then queue its expected bytes
    task automatic drive(t_row r);
        hcbp_pkg::t_out_item [0:4] pred;
        int n;
        int gap;
        if (!quiet_phase && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 9);
            repeat (gap) begin
                @(negedge i_clk);
                i_valid <= 1'b0;
            end
        end
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_item  <= r.item;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pack_step(r.item, pred, n);
        if (r.typed) begin
            for (int k = 0; k < int'(r.n_typed); k++) expected_bytes.push_back(r.exp[k]);
        end else begin
            for (int k = 0; k < n; k++) expected_bytes.push_back(pred[k]);
        end
    endtask

    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stalling   = ($urandom_range(0, 2) == 0);
            stall_left = $urandom_range(1, 9);
        end
        stall_left--;
        i_stall <= stalling && !quiet_phase && i_rst_n;
    end

    always @(posedge i_clk) begin
        hcbp_pkg::t_out_item want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_bytes.size() == 0) begin
                report_error("unexpected transfer", '0, o_item);
            end else begin
                want = expected_bytes.pop_front();
                if (o_item.packed_byte !== want.packed_byte ||
                    o_item.last_of_run !== want.last_of_run ||
                    o_item.is_tail !== want.is_tail) begin
                    report_error("byte mismatch", want, o_item);
                end
            end
        end
        if ((i_rst_n && i_valid && !o_stall) || (i_rst_n && o_valid && !i_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("huffman_code_bit_packer regression: fail");
            $finish;
        end
    end

    initial begin
        t_row r;
        int sent;
        int pick;
        int lsel;
        bit paused;

        add_row(hcbp_pkg::CMD_FLUSH, 8'd0, 32'd0, 6'd0, 0, '0);
        add_row(hcbp_pkg::CMD_LOAD, 8'd0, 32'hFFFF_FFFF, 6'd32, -1, '0);
        add_row(hcbp_pkg::CMD_ENCODE, 8'd0, $urandom, 6'($urandom_range(0, 63)), 4,
                {ob(8'hFF, 1'b0, 1'b0), ob(8'hFF, 1'b0, 1'b0),
                 ob(8'hFF, 1'b0, 1'b0), ob(8'hFF, 1'b1, 1'b0)});
        add_row(hcbp_pkg::CMD_LOAD, 8'd255, 32'd0, 6'd0, -1, '0);
        add_row(hcbp_pkg::CMD_ENCODE, 8'd255, $urandom, 6'($urandom_range(0, 63)), 0, '0);
        add_row(hcbp_pkg::CMD_LOAD, 8'd1, 32'h0000_0001, 6'd1, -1, '0);
        add_row(hcbp_pkg::CMD_ENCODE, 8'd1, $urandom, 6'($urandom_range(0, 63)), 0, '0);
        add_row(hcbp_pkg::CMD_FLUSH, 8'd0, 32'd0, 6'd0, 1, {ob(8'h01, 1'b1, 1'b1), 30'd0});
        // overlong length saturates to a full word
        add_row(hcbp_pkg::CMD_LOAD, 8'd2, 32'hA5A5_A5A5, 6'd63, -1, '0);
        add_row(hcbp_pkg::CMD_ENCODE, 8'd2, $urandom, 6'($urandom_range(0, 63)), 4,
                {ob(8'hA5, 1'b0, 1'b0), ob(8'hA5, 1'b0, 1'b0),
                 ob(8'hA5, 1'b0, 1'b0), ob(8'hA5, 1'b1, 1'b0)});
        add_row(hcbp_pkg::CMD_LOAD, 8'd3, 32'hFFFF_FF80, 6'd7, -1, '0);
        add_row(hcbp_pkg::CMD_ENCODE, 8'd3, $urandom, 6'($urandom_range(0, 63)), 0, '0);
        add_row(CMD_NONE, 8'd0, $urandom, 6'($urandom_range(0, 63)), 0, '0);
        add_row(hcbp_pkg::CMD_ENCODE, 8'd0, $urandom, 6'($urandom_range(0, 63)), -1, '0);
        add_row(hcbp_pkg::CMD_FLUSH, 8'hFF, $urandom, 6'($urandom_range(0, 63)), -1, '0);
        add_row(hcbp_pkg::CMD_LOAD, 8'd4, 32'h8000_0000, 6'd32, -1, '0);
        add_row(hcbp_pkg::CMD_ENCODE, 8'd4, $urandom, 6'($urandom_range(0, 63)), 4,
                {ob(8'h00, 1'b0, 1'b0), ob(8'h00, 1'b0, 1'b0),
                 ob(8'h00, 1'b0, 1'b0), ob(8'h80, 1'b1, 1'b0)});
        add_row(hcbp_pkg::CMD_LOAD, 8'd5, 32'h0000_0003, 6'd33, -1, '0);
        add_row(hcbp_pkg::CMD_ENCODE, 8'd5, $urandom, 6'($urandom_range(0, 63)), 4,
                {ob(8'h03, 1'b0, 1'b0), ob(8'h00, 1'b0, 1'b0),
                 ob(8'h00, 1'b0, 1'b0), ob(8'h00, 1'b1, 1'b0)});
        add_row(hcbp_pkg::CMD_LOAD, 8'd6, 32'h0000_0005, 6'd3, -1, '0);
        add_row(hcbp_pkg::CMD_ENCODE, 8'd6, $urandom, 6'($urandom_range(0, 63)), -1, '0);
        add_row(hcbp_pkg::CMD_ENCODE, 8'd6, $urandom, 6'($urandom_range(0, 63)), -1, '0);
        add_row(hcbp_pkg::CMD_ENCODE, 8'd6, $urandom, 6'($urandom_range(0, 63)), -1, '0);
        add_row(hcbp_pkg::CMD_LOAD, 8'd0, 32'h1234_5678, 6'd13, -1, '0);
        add_row(hcbp_pkg::CMD_ENCODE, 8'd0, $urandom, 6'($urandom_range(0, 63)), -1, '0);

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[k]) drive(dir_rows[k]);

        sent   = 0;
        paused = 1'b0;
        while (sent < RAND_ITEMS) begin
            // hold the input side until the packer has drained
            if (!paused && sent == RAND_ITEMS / 2) begin
                paused = 1'b1;
                @(negedge i_clk);
                i_valid <= 1'b0;
                while (expected_bytes.size() != 0) @(negedge i_clk);
            end
            quiet_phase = (sent >= RAND_ITEMS - QUIET_ITEMS);
            r = '0;
            r.item.symbol      = 8'($urandom_range(0, 255));
            r.item.code_word   = $urandom;
            r.item.code_length = 6'($urandom_range(0, 63));
            pick = $urandom_range(0, 99);
            if (pick < 12 || loaded_syms.size() == 0) begin
                r.item.cmd = hcbp_pkg::CMD_LOAD;
                lsel = $urandom_range(0, 9);
                if (lsel == 0) r.item.code_length = 6'd0;
                else if (lsel <= 5) r.item.code_length = 6'($urandom_range(1, 8));
                else if (lsel <= 7) r.item.code_length = 6'($urandom_range(9, 31));
                else if (lsel == 8) r.item.code_length = 6'd32;
                else r.item.code_length = 6'($urandom_range(33, 63));
            end else if (pick < 20) begin
                r.item.cmd = hcbp_pkg::CMD_FLUSH;
            end else if (pick < 23) begin
                r.item.cmd = CMD_NONE;
            end else begin
                r.item.cmd    = hcbp_pkg::CMD_ENCODE;
                r.item.symbol = loaded_syms[$urandom_range(0, loaded_syms.size() - 1)];
            end
            drive(r);
            if (r.item.cmd != CMD_NONE) sent++;
        end

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("huffman_code_bit_packer regression: pass");
        end else begin
            $display("huffman_code_bit_packer regression: fail");
        end
        $finish;
    end

endmodule
